FILE: rtl/spdc_pkg.sv
// Shared types, codes and fixed-point constants of the settling drive controller.
`default_nettype none

package spdc_pkg;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_TICK   = 2'd1,
        OP_CANCEL = 2'd2,
        OP_DIRECT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_TURN_MODE    = 2'd0,
        REG_GOAL         = 2'd1,
        REG_SPEED_LIMIT  = 2'd2,
        REG_DRIVER_READY = 2'd3
    } reg_index_t;

    localparam logic [2:0] ST_RUNNING   = 3'd0;
    localparam logic [2:0] ST_SUCCEEDED = 3'd1;
    localparam logic [2:0] ST_CANCELED  = 3'd2;
    localparam logic [2:0] ST_APPLIED   = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;

    localparam logic [3:0]  SETTLE_LIMIT      = 4'd10;
    localparam logic [3:0]  SETTLE_MAX        = 4'd15;
    localparam logic [15:0] SPEED_LIMIT_RESET = 16'd65280;
    localparam logic [12:0] TOL_TURN          = 13'd512;
    localparam logic [12:0] TOL_DRIVE         = 13'd6400;

    // x/25 = (x * GYRO_RECIP) >> 21, exact for x < 91180
    localparam logic [16:0] GYRO_RECIP = 17'd83887;
    // x/5 = (x * DIV5_RECIP) >> 22, exact for x < 2**22
    localparam logic [19:0] DIV5_RECIP = 20'd838861;
    // x/3264 = (x * PCT_RECIP) >> 30, exact for x < 335544
    localparam logic [18:0] PCT_RECIP  = 19'd328966;

    // error magnitudes at or above this always hit the speed clamp
    localparam logic [17:0] CLIP_MAG = 18'h20000;

    localparam logic signed [39:0] MEAS_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] MEAS_MIN = 40'sh80_0000_0000;

    typedef struct packed {
        logic               turn_mode;
        logic signed [31:0] goal;
        logic [15:0]        speed_limit;
        logic               driver_ready;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic               gyro_valid;
        logic signed [12:0] gyro_step;
        logic [25:0]        enc_sum;
        logic signed [16:0] direct_left;
        logic signed [16:0] direct_right;
    } front_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               zero_power;
        logic               use_direct;
        logic signed [31:0] error_value;
        logic [17:0]        err_mag;
        logic               err_neg;
        logic signed [16:0] direct_left;
        logic signed [16:0] direct_right;
    } core_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               zero_power;
        logic signed [31:0] error_value;
        logic [16:0]        left_mag;
        logic               left_neg;
        logic [16:0]        right_mag;
        logic               right_neg;
    } drive_t;

endpackage

`default_nettype wire

FILE: rtl/spdc_front.sv
// Input register with gyro step rounding and encoder magnitude sum.
`default_nettype none

module spdc_front
    import spdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [17:0] gyro_rate,
    input  logic               gyro_valid,
    input  logic signed [23:0] tick_front_left,
    input  logic signed [23:0] tick_front_right,
    input  logic signed [23:0] tick_rear_left,
    input  logic signed [23:0] tick_rear_right,
    input  logic signed [16:0] direct_left,
    input  logic signed [16:0] direct_right,
    output logic               fr_valid,
    input  logic               fr_ready,
    output front_t             fr_data
);

    function automatic logic [23:0] mag24(input logic signed [23:0] v);
        mag24 = v[23] ? (~v + 24'd1) : v;
    endfunction

    logic        valid_reg;
    front_t      data_reg;
    front_t      data_next;
    logic        rate_neg;
    logic [17:0] rate_abs;
    logic [17:0] rate_round;
    logic [16:0] rate_half;
    logic [32:0] gyro_prod;
    logic [11:0] step_mag;

    assign in_ready = !valid_reg || fr_ready;
    assign fr_valid = valid_reg;
    assign fr_data  = data_reg;

    always_comb
    begin
        // round |rate|/50 half away from zero: (|r| + 25) / 2 / 25
        rate_neg   = gyro_rate[17];
        rate_abs   = rate_neg ? (~gyro_rate + 18'd1) : gyro_rate;
        rate_round = rate_abs + 18'd25;
        rate_half  = rate_round[17:1];
        gyro_prod  = 33'(rate_half) * 33'(GYRO_RECIP);
        step_mag   = gyro_prod[32:21];

        data_next.op           = op_t'(op);
        data_next.gyro_valid   = gyro_valid;
        data_next.gyro_step    = rate_neg ? -$signed({1'b0, step_mag})
                                          : $signed({1'b0, step_mag});
        data_next.enc_sum      = 26'(mag24(tick_front_left)) + 26'(mag24(tick_front_right))
                               + 26'(mag24(tick_rear_left)) + 26'(mag24(tick_rear_right));
        data_next.direct_left  = direct_left;
        data_next.direct_right = direct_right;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spdc_core.sv
// Run state, measured value, error and settle counting.
`default_nettype none

module spdc_core
    import spdc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   fr_valid,
    output logic   fr_ready,
    input  front_t fr_data,
    output logic   core_valid,
    input  logic   core_ready,
    output core_t  core_data
);

    logic               valid_reg;
    core_t              data_reg;
    core_t              data_next;
    logic               run_active_reg;
    logic               run_active_next;
    logic signed [39:0] meas_reg;
    logic signed [39:0] meas_next;
    logic [3:0]         settle_reg;
    logic [3:0]         settle_next;
    logic               fire;

    logic signed [40:0] gyro_sum;
    logic signed [39:0] gyro_meas;
    logic [39:0]        drive_meas;
    logic signed [39:0] meas_tick;
    logic signed [40:0] err_full;
    logic [40:0]        err_abs;
    logic [12:0]        tol;
    logic               in_tol;
    logic [3:0]         settle_tick;
    logic               settled;

    assign fr_ready   = !valid_reg || core_ready;
    assign fire       = fr_valid && fr_ready;
    assign core_valid = valid_reg;
    assign core_data  = data_reg;

    always_comb
    begin
        gyro_sum = {meas_reg[39], meas_reg}
                 + {{28{fr_data.gyro_step[12]}}, fr_data.gyro_step};
        if (gyro_sum[40] != gyro_sum[39])
        begin
            gyro_meas = gyro_sum[40] ? MEAS_MIN : MEAS_MAX;
        end
        else
        begin
            gyro_meas = gyro_sum[39:0];
        end

        drive_meas = {8'd0, fr_data.enc_sum, 6'd0};
        if (cfg.turn_mode)
        begin
            meas_tick = fr_data.gyro_valid ? gyro_meas : meas_reg;
        end
        else
        begin
            meas_tick = cfg.goal[31] ? -$signed(drive_meas) : $signed(drive_meas);
        end

        err_full = {{9{cfg.goal[31]}}, cfg.goal} - {meas_tick[39], meas_tick};
        err_abs  = err_full[40] ? (~err_full + 41'd1) : err_full;
        tol      = cfg.turn_mode ? TOL_TURN : TOL_DRIVE;
        in_tol   = err_abs < 41'(tol);

        if (!in_tol)
        begin
            settle_tick = 4'd0;
        end
        else if (settle_reg == SETTLE_MAX)
        begin
            settle_tick = settle_reg;
        end
        else
        begin
            settle_tick = settle_reg + 4'd1;
        end
        settled = settle_tick > SETTLE_LIMIT;

        run_active_next = run_active_reg;
        meas_next       = meas_reg;
        settle_next     = settle_reg;

        data_next.status       = ST_RUNNING;
        data_next.zero_power   = 1'b1;
        data_next.use_direct   = 1'b0;
        data_next.error_value  = 32'sd0;
        data_next.err_mag      = (|err_abs[40:17]) ? CLIP_MAG : err_abs[17:0];
        data_next.err_neg      = err_full[40];
        data_next.direct_left  = fr_data.direct_left;
        data_next.direct_right = fr_data.direct_right;

        case (fr_data.op)
            OP_START:
            begin
                run_active_next = 1'b1;
                meas_next       = 40'sd0;
                settle_next     = 4'd0;
            end
            OP_CANCEL:
            begin
                run_active_next  = 1'b0;
                data_next.status = ST_CANCELED;
            end
            OP_DIRECT:
            begin
                if (run_active_reg)
                begin
                    data_next.status = ST_IGNORED;
                end
                else
                begin
                    data_next.status     = ST_APPLIED;
                    data_next.zero_power = 1'b0;
                    data_next.use_direct = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (run_active_reg)
                begin
                    meas_next   = meas_tick;
                    settle_next = settle_tick;
                    if (err_full[40:31] == {10{err_full[31]}})
                    begin
                        data_next.error_value = err_full[31:0];
                    end
                    else
                    begin
                        data_next.error_value = err_full[40] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end
                    if (settled)
                    begin
                        run_active_next  = 1'b0;
                        data_next.status = ST_SUCCEEDED;
                    end
                    else
                    begin
                        data_next.zero_power = 1'b0;
                    end
                end
            end
            default:
            begin
                data_next.status = ST_RUNNING;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            run_active_reg <= 1'b0;
            meas_reg       <= 40'sd0;
            settle_reg     <= 4'd0;
        end
        else
        begin
            if (fr_ready)
            begin
                valid_reg <= fr_valid;
            end
            if (fire)
            begin
                run_active_reg <= run_active_next;
                meas_reg       <= meas_next;
                settle_reg     <= settle_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spdc_drive.sv
// Gain, speed clamp and side sign selection.
`default_nettype none

module spdc_drive
    import spdc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   core_valid,
    output logic   core_ready,
    input  core_t  core_data,
    output logic   drv_valid,
    input  logic   drv_ready,
    output drive_t drv_data
);

    logic        valid_reg;
    drive_t      data_reg;
    drive_t      data_next;
    logic [19:0] err_x3;
    logic [39:0] div_prod;
    logic [18:0] gain_mag;
    logic [15:0] clamp_mag;

    assign core_ready = !valid_reg || drv_ready;
    assign drv_valid  = valid_reg;
    assign drv_data   = data_reg;

    always_comb
    begin
        // drive gain 0.6 as 3x then divide by 5
        err_x3   = {2'd0, core_data.err_mag} + {1'b0, core_data.err_mag, 1'b0};
        div_prod = 40'(err_x3) * 40'(DIV5_RECIP);
        gain_mag = cfg.turn_mode ? {core_data.err_mag, 1'b0} : {1'b0, div_prod[39:22]};
        if (gain_mag > 19'(cfg.speed_limit))
        begin
            clamp_mag = cfg.speed_limit;
        end
        else
        begin
            clamp_mag = gain_mag[15:0];
        end

        data_next.status      = core_data.status;
        data_next.zero_power  = core_data.zero_power;
        data_next.error_value = core_data.error_value;
        if (core_data.use_direct)
        begin
            data_next.left_neg  = core_data.direct_left[16];
            data_next.left_mag  = core_data.direct_left[16] ? (~core_data.direct_left + 17'd1)
                                                            : core_data.direct_left;
            data_next.right_neg = core_data.direct_right[16];
            data_next.right_mag = core_data.direct_right[16] ? (~core_data.direct_right + 17'd1)
                                                             : core_data.direct_right;
        end
        else
        begin
            // turn spins in place: left side runs opposite
            data_next.left_neg  = cfg.turn_mode ? !core_data.err_neg : core_data.err_neg;
            data_next.left_mag  = {1'b0, clamp_mag};
            data_next.right_neg = core_data.err_neg;
            data_next.right_mag = {1'b0, clamp_mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (core_ready)
        begin
            valid_reg <= core_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_valid && core_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spdc_power.sv
// Percent conversion of both sides and the result register.
`default_nettype none

module spdc_power
    import spdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               drv_valid,
    output logic               drv_ready,
    input  drive_t             drv_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [7:0]  left_power,
    output logic signed [7:0]  right_power,
    output logic signed [31:0] error_value,
    output logic [2:0]         status
);

    // trunc(mag * 100 / 65280) = (5 * mag) / 3264
    function automatic logic signed [7:0] to_pct(input logic [16:0] mag, input logic neg);
        logic [18:0] mag_x5;
        logic [37:0] prod;
        logic [7:0]  pct;
        mag_x5 = {2'd0, mag} + {mag, 2'd0};
        prod   = 38'(mag_x5) * 38'(PCT_RECIP);
        pct    = prod[37:30];
        to_pct = neg ? -$signed(pct) : $signed(pct);
    endfunction

    logic               valid_reg;
    logic signed [7:0]  left_reg;
    logic signed [7:0]  right_reg;
    logic signed [31:0] error_reg;
    logic [2:0]         status_reg;
    logic               power_off;

    assign drv_ready   = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign left_power  = left_reg;
    assign right_power = right_reg;
    assign error_value = error_reg;
    assign status      = status_reg;
    assign power_off   = drv_data.zero_power || !cfg.driver_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (drv_ready)
        begin
            valid_reg <= drv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drv_valid && drv_ready)
        begin
            left_reg   <= power_off ? 8'sd0 : to_pct(drv_data.left_mag, drv_data.left_neg);
            right_reg  <= power_off ? 8'sd0 : to_pct(drv_data.right_mag, drv_data.right_neg);
            error_reg  <= drv_data.error_value;
            status_reg <= drv_data.status;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/settling_p_drive_controller.sv
// Top level of the settling proportional drive/turn controller.
//
//  channel | direction | handshake               | contents
//  --------+-----------+-------------------------+------------------------------------
//  config  | in        | cfg_write               | cfg_index, cfg_data
//  request | in        | in_valid / in_ready     | op, gyro, four encoders, direct speeds
//  result  | out       | out_valid / out_ready   | left/right power, error, status
//
// Four register stages (input, core, gain, power); a request passes through them in
// that order, and one request is taken every cycle while the result is not stalled.
// The run state, measured value and settle count update in the core stage, one
// request per cycle when not stalled, so consecutive ticks see each other's state.
// A stalled result holds its register; earlier stages keep filling until full.
// Reset clears the run state and loads the register defaults.
`default_nettype none

module settling_p_drive_controller
    import spdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic signed [17:0] gyro_rate,
    input  logic               gyro_valid,
    input  logic signed [23:0] tick_front_left,
    input  logic signed [23:0] tick_front_right,
    input  logic signed [23:0] tick_rear_left,
    input  logic signed [23:0] tick_rear_right,
    input  logic signed [16:0] direct_left,
    input  logic signed [16:0] direct_right,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [7:0]  left_power,
    output logic signed [7:0]  right_power,
    output logic signed [31:0] error_value,
    output logic [2:0]         status
);

    cfg_t   cfg_reg;
    logic   fr_valid;
    logic   fr_ready;
    front_t fr_data;
    logic   core_valid;
    logic   core_ready;
    core_t  core_data;
    logic   drv_valid;
    logic   drv_ready;
    drive_t drv_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.turn_mode    <= 1'b0;
            cfg_reg.goal         <= 32'sd0;
            cfg_reg.speed_limit  <= SPEED_LIMIT_RESET;
            cfg_reg.driver_ready <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_TURN_MODE:    cfg_reg.turn_mode    <= cfg_data[0];
                REG_GOAL:         cfg_reg.goal         <= cfg_data;
                REG_SPEED_LIMIT:  cfg_reg.speed_limit  <= cfg_data[15:0];
                REG_DRIVER_READY: cfg_reg.driver_ready <= cfg_data[0];
                default:          cfg_reg.turn_mode    <= cfg_reg.turn_mode;
            endcase
        end
    end

    spdc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .gyro_rate        (gyro_rate),
        .gyro_valid       (gyro_valid),
        .tick_front_left  (tick_front_left),
        .tick_front_right (tick_front_right),
        .tick_rear_left   (tick_rear_left),
        .tick_rear_right  (tick_rear_right),
        .direct_left      (direct_left),
        .direct_right     (direct_right),
        .fr_valid         (fr_valid),
        .fr_ready         (fr_ready),
        .fr_data          (fr_data)
    );

    spdc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fr_valid   (fr_valid),
        .fr_ready   (fr_ready),
        .fr_data    (fr_data),
        .core_valid (core_valid),
        .core_ready (core_ready),
        .core_data  (core_data)
    );

    spdc_drive u_drive (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .core_valid (core_valid),
        .core_ready (core_ready),
        .core_data  (core_data),
        .drv_valid  (drv_valid),
        .drv_ready  (drv_ready),
        .drv_data   (drv_data)
    );

    spdc_power u_power (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .drv_valid   (drv_valid),
        .drv_ready   (drv_ready),
        .drv_data    (drv_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .left_power  (left_power),
        .right_power (right_power),
        .error_value (error_value),
        .status      (status)
    );

endmodule

`default_nettype wire

FILE: rtl/spdc_checker.sv
// Port-level checks on the controller results, bound to the top level.
`default_nettype none

module spdc_checker
    import spdc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [7:0]  left_power,
    input logic signed [7:0]  right_power,
    input logic signed [31:0] error_value,
    input logic [2:0]         status
);

    logic stop_status;
    logic no_error_status;

    assign stop_status     = (status == ST_SUCCEEDED) || (status == ST_CANCELED)
                          || (status == ST_IGNORED);
    assign no_error_status = (status == ST_CANCELED) || (status == ST_APPLIED)
                          || (status == ST_IGNORED);

    // stop results never drive the motors
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stop_status |-> left_power == 8'sd0 && right_power == 8'sd0)
        else $error("stop result carries nonzero power");

    a_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_error_status |-> error_value == 32'sd0)
        else $error("non-control result carries an error value");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> left_power >= -8'sd100 && left_power <= 8'sd100
                   && right_power >= -8'sd100 && right_power <= 8'sd100)
        else $error("power outside percent range");

    // a result must not appear unless a request was taken earlier or a result was already valid
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 4) || $past(out_valid))
        else $error("result without a matching request");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_power)
                                  && $stable(error_value) && $stable(status))
        else $error("stalled result changed");

endmodule

bind settling_p_drive_controller spdc_checker u_spdc_checker (.*);

`default_nettype wire

FILE: bench/settling_p_drive_controller_tb.sv
// Self-checking testbench for the settling drive controller: directed and random requests.
module settling_p_drive_controller_tb;
    import spdc_pkg::*;

    localparam longint ERR_TOP    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint ERR_BOT    = -ERR_TOP - 1;
    localparam longint MEAS_TOP   = 64'sh0000_007F_FFFF_FFFF;
    localparam longint MEAS_BOT   = -MEAS_TOP - 1;
    localparam longint FULL_SCALE = 65280;
    localparam longint GYRO_TOP   = 131071;
    localparam longint ENC_TOP    = 8388607;

    typedef struct packed {
        op_t                op;
        logic signed [17:0] gyro_rate;
        logic               gyro_valid;
        logic signed [23:0] fl;
        logic signed [23:0] fr;
        logic signed [23:0] rl;
        logic signed [23:0] rr;
        logic signed [16:0] dl;
        logic signed [16:0] dr;
    } request_t;

    typedef struct packed {
        logic signed [7:0]  left_pw;
        logic signed [7:0]  right_pw;
        logic signed [31:0] err;
        logic [2:0]         status;
    } report_t;

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    class report_scoreboard;
        bit                 turn_on;
        logic signed [31:0] target;
        logic [15:0]        speed_cap;
        bit                 drv_ready;
        bit                 run_on;
        longint             measured;
        int                 settle;
        report_t            due_reports[$];
        int                 errors;
        int                 n_checked;
        int                 n_settled;
        int                 n_canceled;
        int                 n_applied;
        int                 n_ignored;

        function new();
            turn_on = 1'b0;
            target = '0;
            speed_cap = SPEED_LIMIT_RESET;
            drv_ready = 1'b1;
            run_on = 1'b0;
            measured = 0;
            settle = 0;
            errors = 0;
            n_checked = 0;
            n_settled = 0;
            n_canceled = 0;
            n_applied = 0;
            n_ignored = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [31:0] data);
            case (idx)
                REG_TURN_MODE:    turn_on = data[0];
                REG_GOAL:         target = data;
                REG_SPEED_LIMIT:  speed_cap = data[15:0];
                REG_DRIVER_READY: drv_ready = data[0];
                default: ;
            endcase
        endfunction

        function longint percent(longint v);
            longint p;
            p = (v * 100) / FULL_SCALE;
            if (p > 100)
                p = 100;
            if (p < -100)
                p = -100;
            return p;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // Advance the run state by one request and queue the report it produces.
        function void note_request(request_t r);
            report_t e;
            longint  rate;
            longint  delta;
            longint  enc_total;
            longint  tgt;
            longint  err;
            longint  drv;
            longint  cap;
            longint  pw;
            longint  tol;
            e = '0;
            tgt = longint'(target);
            cap = longint'(speed_cap);
            case (r.op)
                OP_START:
                begin
                    measured = 0;
                    settle = 0;
                    run_on = 1'b1;
                    e.status = ST_RUNNING;
                end
                OP_CANCEL:
                begin
                    run_on = 1'b0;
                    e.status = ST_CANCELED;
                end
                OP_DIRECT:
                begin
                    if (run_on)
                        e.status = ST_IGNORED;
                    else
                    begin
                        e.left_pw = 8'(percent(longint'($signed(r.dl))));
                        e.right_pw = 8'(percent(longint'($signed(r.dr))));
                        e.status = ST_APPLIED;
                    end
                end
                default:
                begin
                    e.status = ST_RUNNING;
                    if (run_on)
                    begin
                        if (turn_on)
                        begin
                            // integrate rate/50, rounded half away from zero; hold on a bad read
                            if (r.gyro_valid)
                            begin
                                rate = longint'($signed(r.gyro_rate));
                                delta = (rate >= 0) ? (rate + 25) / 50 : -((25 - rate) / 50);
                                measured = measured + delta;
                                if (measured > MEAS_TOP)
                                    measured = MEAS_TOP;
                                if (measured < MEAS_BOT)
                                    measured = MEAS_BOT;
                            end
                        end
                        else
                        begin
                            enc_total = mag($signed(r.fl)) + mag($signed(r.fr))
                                      + mag($signed(r.rl)) + mag($signed(r.rr));
                            enc_total = enc_total * 64;
                            measured = (tgt < 0) ? -enc_total : enc_total;
                        end
                        err = tgt - measured;
                        drv = turn_on ? err * 2 : (err * 3) / 5;
                        if (drv > cap)
                            drv = cap;
                        if (drv < -cap)
                            drv = -cap;
                        pw = percent(drv);
                        tol = turn_on ? longint'(TOL_TURN) : longint'(TOL_DRIVE);
                        if (mag(err) < tol)
                        begin
                            if (settle < SETTLE_MAX)
                                settle++;
                        end
                        else
                            settle = 0;
                        if (err > ERR_TOP)
                            e.err = 32'h7FFF_FFFF;
                        else if (err < ERR_BOT)
                            e.err = 32'h8000_0000;
                        else
                            e.err = err[31:0];
                        if (settle > SETTLE_LIMIT)
                        begin
                            run_on = 1'b0;
                            e.status = ST_SUCCEEDED;
                        end
                        else
                        begin
                            e.left_pw = 8'(turn_on ? -pw : pw);
                            e.right_pw = 8'(pw);
                        end
                    end
                end
            endcase
            if (!drv_ready)
            begin
                e.left_pw = '0;
                e.right_pw = '0;
            end
            due_reports.push_back(e);
        endfunction

        function void check_report(report_t a);
            report_t e;
            if (due_reports.size() == 0)
            begin
                errors++;
                $display("%0t: report with no request outstanding: l=%0d r=%0d err=%0d st=%0d",
                         $time, a.left_pw, a.right_pw, a.err, a.status);
                return;
            end
            e = due_reports.pop_front();
            n_checked++;
            if (a.left_pw !== e.left_pw || a.right_pw !== e.right_pw ||
                a.err !== e.err || a.status !== e.status)
            begin
                errors++;
                $display("%0t: mismatch, expected l=%0d r=%0d err=%0d st=%0d", $time,
                         e.left_pw, e.right_pw, e.err, e.status,
                         "; got l=%0d r=%0d err=%0d st=%0d",
                         a.left_pw, a.right_pw, a.err, a.status);
            end
            case (e.status)
                ST_SUCCEEDED: n_settled++;
                ST_CANCELED:  n_canceled++;
                ST_APPLIED:   n_applied++;
                ST_IGNORED:   n_ignored++;
                default: ;
            endcase
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic signed [17:0] gyro_rate;
    logic               gyro_valid;
    logic signed [23:0] tick_front_left;
    logic signed [23:0] tick_front_right;
    logic signed [23:0] tick_rear_left;
    logic signed [23:0] tick_rear_right;
    logic signed [16:0] direct_left;
    logic signed [16:0] direct_right;
    logic               out_valid;
    logic               out_ready;
    logic signed [7:0]  left_power;
    logic signed [7:0]  right_power;
    logic signed [31:0] error_value;
    logic [2:0]         status;

    report_scoreboard sb = new();

    int req_taken = 0;
    int items_sent = 0;
    int burst_left = 0;
    int settings = 1;
    int stall_mode = 0;
    int stall_cycle = 0;
    bit gaps_on = 1'b0;

    settling_p_drive_controller u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_report(report_t'{left_power, right_power, error_value, status});
            if (in_valid && in_ready)
            begin
                sb.note_request(request_t'{op_t'(op), gyro_rate, gyro_valid,
                                           tick_front_left, tick_front_right,
                                           tick_rear_left, tick_rear_right,
                                           direct_left, direct_right});
                req_taken <= req_taken + 1;
            end
        end
    end

    // receiver back-pressure, chosen per phase
    always @(negedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ((stall_cycle % 7) < 3);
            default: out_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Call at a falling edge; returns at the falling edge after the request is taken.
    task automatic send(request_t r);
        int seen;
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        op <= r.op;
        gyro_rate <= r.gyro_rate;
        gyro_valid <= r.gyro_valid;
        tick_front_left <= r.fl;
        tick_front_right <= r.fr;
        tick_rear_left <= r.rl;
        tick_rear_right <= r.rr;
        direct_left <= r.dl;
        direct_right <= r.dr;
        in_valid <= 1'b1;
        seen = req_taken;
        do
            @(negedge clk);
        while (req_taken == seen);
        items_sent++;
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Drop valid and drain every outstanding report.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic request_t make_request(op_t o, int rate, bit gv, int fl, int fr,
                                              int rl, int rr, int dl, int dr);
        request_t r;
        r.op = o;
        r.gyro_rate = 18'(rate);
        r.gyro_valid = gv;
        r.fl = 24'(fl);
        r.fr = 24'(fr);
        r.rl = 24'(rl);
        r.rr = 24'(rr);
        r.dl = 17'(dl);
        r.dr = 17'(dr);
        return r;
    endfunction

    function automatic request_t noise_request();
        request_t r;
        r.op = op_t'($urandom_range(0, 3));
        r.gyro_rate = 18'($urandom);
        r.gyro_valid = 1'($urandom);
        r.fl = 24'($urandom);
        r.fr = 24'($urandom);
        r.rl = 24'($urandom);
        r.rr = 24'($urandom);
        r.dl = 17'(int'($urandom_range(0, 130560)) - 65280);
        r.dr = 17'(int'($urandom_range(0, 130560)) - 65280);
        return r;
    endfunction

    // Ramp toward the goal count over five ticks, then hover; now and then a wild count.
    function automatic logic signed [23:0] enc_value(longint goal, int step);
        longint v;
        if ($urandom_range(0, 59) == 0)
            return 24'($urandom);
        v = goal * ((step < 5) ? step : 5) / 5 + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > ENC_TOP)
            v = ENC_TOP;
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return 24'(v);
    endfunction

    function automatic request_t tick_request(int step);
        request_t r;
        longint   goal;
        longint   rate;
        r = noise_request();
        r.op = OP_TICK;
        if (sb.turn_on)
        begin
            // steer the rate so one tick would close the gap, with jitter and overshoot
            rate = (longint'(sb.target) - sb.measured) * 50 + int'($urandom_range(0, 400)) - 200;
            if ($urandom_range(0, 4) == 0)
                rate = rate * 3 / 2;
            if (rate > GYRO_TOP)
                rate = GYRO_TOP;
            if (rate < -GYRO_TOP - 1)
                rate = -GYRO_TOP - 1;
            r.gyro_rate = 18'(rate);
            r.gyro_valid = ($urandom_range(0, 9) != 0);
        end
        else
        begin
            goal = mag(longint'(sb.target)) / 256;
            r.fl = enc_value(goal, step);
            r.fr = enc_value(goal, step);
            r.rl = enc_value(goal, step);
            r.rr = enc_value(goal, step);
        end
        return r;
    endfunction

    // One run: start, ticks until settled, canceled or timed out, stray requests mixed in.
    task automatic run_sequence();
        int       step;
        int       limit;
        request_t r;
        limit = sb.turn_on ? 40 : 25;
        r = noise_request();
        r.op = OP_START;
        send(r);
        step = 0;
        while (sb.run_on && step < limit)
        begin
            step++;
            if ($urandom_range(0, 15) == 0)
            begin
                r = noise_request();
                if (r.op == OP_START)
                    step = 0;
            end
            else
                r = tick_request(step);
            send(r);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            r = noise_request();
            r.op = OP_DIRECT;
            send(r);
        end
    endtask

    task automatic configure(int phase);
        bit          turn;
        int          sel;
        logic [31:0] tgt;
        logic [15:0] cap;
        turn = (phase < 4) ? 1'(phase % 2) : 1'($urandom_range(0, 1));
        sel = (phase < 3) ? phase : $urandom_range(0, 9);
        case (sel)
            0:       tgt = 32'h7FFF_FFFF;
            1:       tgt = 32'h8000_0000;
            2:       tgt = 32'h0;
            default: tgt = turn ? 32'(int'($urandom_range(0, 92160)) - 46080)
                                : 32'(int'($urandom_range(0, 512000000)) - 256000000);
        endcase
        sel = (phase < 3) ? phase : $urandom_range(0, 5);
        case (sel)
            0:       cap = 16'h0;
            1:       cap = 16'hFFFF;
            2:       cap = SPEED_LIMIT_RESET;
            default: cap = 16'($urandom);
        endcase
        write_reg(REG_TURN_MODE, 32'(turn));
        write_reg(REG_GOAL, tgt);
        write_reg(REG_SPEED_LIMIT, 32'(cap));
        write_reg(REG_DRIVER_READY, (phase == 1) ? 32'd0 : 32'($urandom_range(0, 4) != 0));
        settings++;
        stall_mode = phase % 4;
        gaps_on = (phase % 3 != 0);
    endtask

    initial
    begin
        int phase;
        int phase_end;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = '0;
        gyro_rate = '0;
        gyro_valid = 1'b0;
        tick_front_left = '0;
        tick_front_right = '0;
        tick_rear_left = '0;
        tick_rear_right = '0;
        direct_left = '0;
        direct_right = '0;
        out_ready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset defaults: drive mode, zero target, full speed, driver present
        send(make_request(OP_TICK, 131071, 1, 8388607, -8388608, 8388607, -8388608,
                          65280, -65280));
        send(make_request(OP_DIRECT, 0, 0, 0, 0, 0, 0, 65280, -65280));
        send(make_request(OP_DIRECT, 0, 0, 0, 0, 0, 0, -1, 255));
        send(make_request(OP_DIRECT, 0, 0, 0, 0, 0, 0, -65280, 65280));
        send(make_request(OP_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make_request(OP_START, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make_request(OP_DIRECT, 0, 0, 0, 0, 0, 0, 1000, 1000));
        send(make_request(OP_TICK, 0, 0, 8388607, -8388608, 8388607, -8388608, 0, 0));
        send(make_request(OP_START, 0, 0, 0, 0, 0, 0, 0, 0));
        // zero error on every tick: settles on the eleventh
        repeat (11) send(make_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        settle_idle();

        write_reg(REG_TURN_MODE, 32'd1);
        write_reg(REG_GOAL, 32'd23040);
        send(make_request(OP_START, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make_request(OP_TICK, 131071, 1, 0, 0, 0, 0, 0, 0));
        send(make_request(OP_TICK, -131072, 0, 0, 0, 0, 0, 0, 0));
        send(make_request(OP_TICK, -131072, 1, 0, 0, 0, 0, 0, 0));
        send(make_request(OP_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0));
        settle_idle();

        phase = 0;
        while (items_sent < 550)
        begin
            configure(phase);
            phase_end = items_sent + 45;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 4) != 0)
                    run_sequence();
                else
                    send(noise_request());
            end
            settle_idle();
            phase++;
        end
        repeat (20) @(negedge clk);

        $display("Sent %0d requests over %0d register settings; %0d reports checked.",
                 items_sent, settings, sb.n_checked);
        $display("Runs settled %0d, canceled %0d, direct applied %0d, direct ignored %0d.",
                 sb.n_settled, sb.n_canceled, sb.n_applied, sb.n_ignored);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
